>>> src/rwtv_pkg.sv
package rwtv_pkg;

   localparam int CoordW = 32;
   localparam int PatchW = 8;
   localparam int DiffW  = 33;
   localparam int IdxW   = 4;

   localparam logic [IdxW-1:0] REG_AXIS_A_X       = IdxW'(0);
   localparam logic [IdxW-1:0] REG_AXIS_A_Y       = IdxW'(1);
   localparam logic [IdxW-1:0] REG_AXIS_A_Z       = IdxW'(2);
   localparam logic [IdxW-1:0] REG_AXIS_B_X       = IdxW'(3);
   localparam logic [IdxW-1:0] REG_AXIS_B_Y       = IdxW'(4);
   localparam logic [IdxW-1:0] REG_AXIS_B_Z       = IdxW'(5);
   localparam logic [IdxW-1:0] REG_ANGULAR_RATE   = IdxW'(6);
   localparam logic [IdxW-1:0] REG_TARGET_PATCH   = IdxW'(7);

   localparam logic signed [CoordW-1:0] AxisBZReset = CoordW'(65536);

   typedef struct packed {
      logic signed [CoordW-1:0] a_x;
      logic signed [CoordW-1:0] a_y;
      logic signed [CoordW-1:0] a_z;
      logic signed [CoordW-1:0] b_x;
      logic signed [CoordW-1:0] b_y;
      logic signed [CoordW-1:0] b_z;
      logic signed [CoordW-1:0] rate;
      logic [PatchW-1:0]        patch;
   } cfg_type;

   typedef struct packed {
      logic signed [DiffW-1:0] x;
      logic signed [DiffW-1:0] y;
      logic signed [DiffW-1:0] z;
   } offset_type;

   typedef struct packed {
      logic signed [CoordW-1:0] vel_x;
      logic signed [CoordW-1:0] vel_y;
      logic signed [CoordW-1:0] vel_z;
      logic                     degenerate;
   } result_type;

endpackage

>>> src/rwtv_queue.sv
module rwtv_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   // DEPTH must be at least 2.
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/rwtv_front.sv
module rwtv_front import rwtv_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic signed [CoordW-1:0] node_x,
   input  logic signed [CoordW-1:0] node_y,
   input  logic signed [CoordW-1:0] node_z,
   input  logic [PatchW-1:0]        node_patch,
   output logic                     q_push,
   output offset_type               q_data,
   input  logic                     q_full
);

   typedef struct packed {
      logic       match;
      offset_type off;
   } front_type;

   logic      fv_ff, fv_in;
   front_type fs_ff, fs_in;
   logic      accept, move;

   // A request of another patch is dropped here and never reaches the queue.
   assign move     = !fs_ff.match || !q_full;
   assign req_full = fv_ff && !move;
   assign accept   = req_push && !req_full;
   assign q_push   = fv_ff && fs_ff.match && !q_full;
   assign q_data   = fs_ff.off;

   always_comb begin
      fv_in       = accept || (fv_ff && !move);
      fs_in.match = (node_patch == cfg.patch);
      fs_in.off.x = DiffW'(node_x) - DiffW'(cfg.a_x);
      fs_in.off.y = DiffW'(node_y) - DiffW'(cfg.a_y);
      fs_in.off.z = DiffW'(node_z) - DiffW'(cfg.a_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
      end else begin
         fv_ff <= fv_in;
      end
      if (accept) begin
         fs_ff <= fs_in;
      end
   end

endmodule

>>> src/rwtv_back.sv
module rwtv_back import rwtv_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       q_empty,
   input  offset_type q_data,
   output logic       q_pop,
   output logic       out_push,
   output result_type out_data,
   input  logic       out_full
);

   localparam int ProdW  = 2 * DiffW;
   localparam int CrossW = ProdW + 1;
   localparam int MagW   = ProdW;
   localparam int PlenW  = ProdW;
   localparam int Shift  = 32;
   localparam int RadW   = PlenW + Shift;
   localparam int RootW  = RadW / 2;
   localparam int SqRemW = RootW + 1;
   localparam int HalfW  = MagW / 2;
   localparam int PpW    = HalfW + CoordW;
   localparam int NumW   = PpW + HalfW;
   localparam int QW     = CoordW;
   localparam int QrW    = QW + 1;

   typedef struct packed {
      logic signed [ProdW-1:0] yz, zy, zx, xz, xy, yx;
      logic [ProdW-1:0]        sx, sy, sz;
   } s1_type;

   typedef struct packed {
      logic [2:0][MagW-1:0] cmag;
      logic [2:0]           cneg;
      logic [PlenW-1:0]     plen2;
      logic                 degen;
   } s2_type;

   typedef struct packed {
      logic [RootW-1:0]     root;
      logic [SqRemW-1:0]    rem;
      logic [PlenW-1:0]     plen2;
      logic [2:0][MagW-1:0] cmag;
      logic [2:0]           cneg;
      logic                 degen;
   } sq_type;

   typedef struct packed {
      logic [2:0][PpW-1:0] plo;
      logic [2:0][PpW-1:0] phi;
      logic [2:0]          neg;
      logic [RootW-1:0]    len;
      logic                degen;
   } m1_type;

   typedef struct packed {
      logic [2:0][NumW-1:0] num;
      logic [2:0]           neg;
      logic [RootW-1:0]     len;
      logic                 degen;
   } m2_type;

   typedef struct packed {
      logic [2:0][RootW-1:0] rem;
      logic [2:0][QW-1:0]    lo;
      logic [2:0][QW-1:0]    q;
      logic [2:0]            ovf;
      logic [2:0]            neg;
      logic [RootW-1:0]      len;
      logic                  degen;
   } dv_type;

   typedef struct packed {
      logic [2:0][QrW-1:0] qr;
      logic [2:0]          ovf;
      logic [2:0]          neg;
      logic                degen;
   } r1_type;

   logic adv;

   logic signed [DiffW-1:0] p_x, p_y, p_z;
   logic                    rneg;
   logic [CoordW-1:0]       rmag;

   logic   s1_v_ff, s2_v_ff, m1_v_ff, m2_v_ff, d0_v_ff, r1_v_ff;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   m1_type m1_ff, m1_in;
   m2_type m2_ff, m2_in;
   dv_type d0_ff, d0_in;
   r1_type r1_ff, r1_in;

   logic [RootW-1:0] sq_v_ff;
   sq_type           sq_src [RootW];
   sq_type           sq_in  [RootW];
   sq_type           sq_ff  [RootW];

   logic [QW-1:0] dv_v_ff;
   dv_type        dv_src [QW];
   dv_type        dv_in  [QW];
   dv_type        dv_ff  [QW];

   // The whole back pipeline holds while its last stage cannot hand off.
   assign adv   = !(r1_v_ff && out_full);
   assign q_pop = adv && !q_empty;

   // User must hold axis and rate static while requests are in flight; unchecked.
   assign p_x  = DiffW'(cfg.b_x) - DiffW'(cfg.a_x);
   assign p_y  = DiffW'(cfg.b_y) - DiffW'(cfg.a_y);
   assign p_z  = DiffW'(cfg.b_z) - DiffW'(cfg.a_z);
   assign rneg = cfg.rate[CoordW-1];
   assign rmag = rneg ? CoordW'(-cfg.rate) : CoordW'(cfg.rate);

   always_comb begin
      s1_in.yz = p_y * q_data.z;
      s1_in.zy = p_z * q_data.y;
      s1_in.zx = p_z * q_data.x;
      s1_in.xz = p_x * q_data.z;
      s1_in.xy = p_x * q_data.y;
      s1_in.yx = p_y * q_data.x;
      s1_in.sx = p_x * p_x;
      s1_in.sy = p_y * p_y;
      s1_in.sz = p_z * p_z;
   end

   always_comb begin
      logic signed [2:0][CrossW-1:0] c;
      c[0] = CrossW'(s1_ff.yz) - CrossW'(s1_ff.zy);
      c[1] = CrossW'(s1_ff.zx) - CrossW'(s1_ff.xz);
      c[2] = CrossW'(s1_ff.xy) - CrossW'(s1_ff.yx);
      s2_in.plen2 = s1_ff.sx + s1_ff.sy + s1_ff.sz;
      for (int i = 0; i < 3; i++) begin
         s2_in.cneg[i] = c[i][CrossW-1];
         s2_in.cmag[i] = c[i][CrossW-1] ? MagW'(-c[i]) : MagW'(c[i]);
      end
      s2_in.degen = (s2_in.plen2 == '0) || (c == '0);
   end

   always_comb begin
      sq_src[0].root  = '0;
      sq_src[0].rem   = '0;
      sq_src[0].plen2 = s2_ff.plen2;
      sq_src[0].cmag  = s2_ff.cmag;
      sq_src[0].cneg  = s2_ff.cneg;
      sq_src[0].degen = s2_ff.degen;
   end

   // Square root of plen2 * 2^32, one result bit per stage.
   for (genvar k = 0; k < RootW; k++) begin : g_sqrt
      localparam int Lo = RadW - 2 - 2 * k;
      logic [1:0] pair;

      if (k > 0) begin : g_link
         assign sq_src[k] = sq_ff[k-1];
      end

      if (Lo >= Shift) begin : g_pair
         assign pair = sq_src[k].plen2[Lo-Shift+1 -: 2];
      end else begin : g_zero
         assign pair = 2'b00;
      end

      always_comb begin
         logic [SqRemW+1:0] t;
         logic [SqRemW+1:0] trial;
         t         = {sq_src[k].rem, pair};
         trial     = (SqRemW+2)'({sq_src[k].root, 2'b01});
         sq_in[k]  = sq_src[k];
         if (t >= trial) begin
            sq_in[k].rem  = SqRemW'(t - trial);
            sq_in[k].root = {sq_src[k].root[RootW-2:0], 1'b1};
         end else begin
            sq_in[k].rem  = SqRemW'(t);
            sq_in[k].root = {sq_src[k].root[RootW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[k] <= (k == 0) ? s2_v_ff : sq_v_ff[(k == 0) ? 0 : k - 1];
         end
         if (adv) begin
            sq_ff[k] <= sq_in[k];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m1_in.plo[i] = PpW'(sq_ff[RootW-1].cmag[i][HalfW-1:0]) * PpW'(rmag);
         m1_in.phi[i] = PpW'(sq_ff[RootW-1].cmag[i][MagW-1:HalfW]) * PpW'(rmag);
         m1_in.neg[i] = sq_ff[RootW-1].cneg[i] ^ rneg;
      end
      m1_in.len   = sq_ff[RootW-1].root;
      m1_in.degen = sq_ff[RootW-1].degen;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m2_in.num[i] = (NumW'(m1_ff.phi[i]) << HalfW) + NumW'(m1_ff.plo[i]);
      end
      m2_in.neg   = m1_ff.neg;
      m2_in.len   = m1_ff.len;
      m2_in.degen = m1_ff.degen;
   end

   // A quotient of 2^32 or more saturates in any case, so only 32 bits are formed.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d0_in.ovf[i] = m2_ff.num[i][NumW-1:QW] >= (NumW-QW)'(m2_ff.len);
         d0_in.rem[i] = m2_ff.num[i][QW+RootW-1:QW];
         d0_in.lo[i]  = m2_ff.num[i][QW-1:0];
         d0_in.q[i]   = '0;
      end
      d0_in.neg   = m2_ff.neg;
      d0_in.len   = m2_ff.len;
      d0_in.degen = m2_ff.degen;
   end

   assign dv_src[0] = d0_ff;

   for (genvar j = 0; j < QW; j++) begin : g_div
      if (j > 0) begin : g_link
         assign dv_src[j] = dv_ff[j-1];
      end

      always_comb begin
         logic [RootW:0] t;
         dv_in[j] = dv_src[j];
         for (int i = 0; i < 3; i++) begin
            t = {dv_src[j].rem[i], dv_src[j].lo[i][QW-1-j]};
            if (t >= {1'b0, dv_src[j].len}) begin
               dv_in[j].rem[i] = RootW'(t - {1'b0, dv_src[j].len});
               dv_in[j].q[i]   = {dv_src[j].q[i][QW-2:0], 1'b1};
            end else begin
               dv_in[j].rem[i] = t[RootW-1:0];
               dv_in[j].q[i]   = {dv_src[j].q[i][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[j] <= (j == 0) ? d0_v_ff : dv_v_ff[(j == 0) ? 0 : j - 1];
         end
         if (adv) begin
            dv_ff[j] <= dv_in[j];
         end
      end
   end

   // Round to nearest, halves away from zero.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         r1_in.qr[i] = QrW'(dv_ff[QW-1].q[i]) +
                       QrW'({dv_ff[QW-1].rem[i], 1'b0} >= {1'b0, dv_ff[QW-1].len});
      end
      r1_in.ovf   = dv_ff[QW-1].ovf;
      r1_in.neg   = dv_ff[QW-1].neg;
      r1_in.degen = dv_ff[QW-1].degen;
   end

   always_comb begin
      logic [2:0][QrW-1:0]    lim;
      logic [2:0][QrW-1:0]    mag;
      logic [2:0][CoordW-1:0] v;
      for (int i = 0; i < 3; i++) begin
         lim[i] = r1_ff.neg[i] ? (QrW'(1) << (QW - 1)) : ((QrW'(1) << (QW - 1)) - 1'b1);
         mag[i] = (r1_ff.ovf[i] || r1_ff.qr[i] > lim[i]) ? lim[i] : r1_ff.qr[i];
         v[i]   = r1_ff.neg[i] ? CoordW'(-mag[i]) : CoordW'(mag[i]);
         if (r1_ff.degen) begin
            v[i] = '0;
         end
      end
      out_data.vel_x      = v[0];
      out_data.vel_y      = v[1];
      out_data.vel_z      = v[2];
      out_data.degenerate = r1_ff.degen;
   end

   assign out_push = adv && r1_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0;
         d0_v_ff <= 1'b0;
         r1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= !q_empty;
         s2_v_ff <= s1_v_ff;
         m1_v_ff <= sq_v_ff[RootW-1];
         m2_v_ff <= m1_v_ff;
         d0_v_ff <= m2_v_ff;
         r1_v_ff <= dv_v_ff[QW-1];
      end
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         m1_ff <= m1_in;
         m2_ff <= m2_in;
         d0_ff <= d0_in;
         r1_ff <= r1_in;
      end
   end

endmodule

>>> src/rotating_wall_tangential_velocity_core.sv
// Channel   Direction  Handshake             Payload
// req_      in         req_push / req_full   node_x, node_y, node_z, node_patch
// rsp_      out        rsp_pop / rsp_empty   vel_x, vel_y, vel_z, degenerate
// csr_      in         csr_valid / csr_ready csr_index, csr_wdata
//
// One request per cycle is accepted while req_full is low. A request of the
// selected patch passes the 49-stage square root and the 32-stage divider on
// its way to the result side. Reset restores the register defaults and empties
// both queues. When results are not taken, the back pipeline holds and the
// middle queue and then req_full take up the pressure.
module rotating_wall_tangential_velocity_core import rwtv_pkg::*; #(
   parameter int MID_DEPTH = 4,
   parameter int OUT_DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic signed [CoordW-1:0] req_node_x,
   input  logic signed [CoordW-1:0] req_node_y,
   input  logic signed [CoordW-1:0] req_node_z,
   input  logic [PatchW-1:0]        req_node_patch,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic signed [CoordW-1:0] rsp_vel_x,
   output logic signed [CoordW-1:0] rsp_vel_y,
   output logic signed [CoordW-1:0] rsp_vel_z,
   output logic                     rsp_degenerate,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [IdxW-1:0]          csr_index,
   input  logic [CoordW-1:0]        csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   logic       mid_push, mid_full, mid_pop, mid_empty;
   offset_type mid_wdata, mid_rdata;
   logic       out_push, out_full;
   result_type out_wdata, out_rdata;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_AXIS_A_X:     cfg_in.a_x   = csr_wdata;
            REG_AXIS_A_Y:     cfg_in.a_y   = csr_wdata;
            REG_AXIS_A_Z:     cfg_in.a_z   = csr_wdata;
            REG_AXIS_B_X:     cfg_in.b_x   = csr_wdata;
            REG_AXIS_B_Y:     cfg_in.b_y   = csr_wdata;
            REG_AXIS_B_Z:     cfg_in.b_z   = csr_wdata;
            REG_ANGULAR_RATE: cfg_in.rate  = csr_wdata;
            REG_TARGET_PATCH: cfg_in.patch = csr_wdata[PatchW-1:0];
            default:          cfg_in       = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{b_z: AxisBZReset, default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rwtv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_push   (req_push),
      .req_full   (req_full),
      .node_x     (req_node_x),
      .node_y     (req_node_y),
      .node_z     (req_node_z),
      .node_patch (req_node_patch),
      .q_push     (mid_push),
      .q_data     (mid_wdata),
      .q_full     (mid_full)
   );

   rwtv_queue #(
      .WIDTH ($bits(offset_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_wdata),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_rdata),
      .empty     (mid_empty)
   );

   rwtv_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_empty  (mid_empty),
      .q_data   (mid_rdata),
      .q_pop    (mid_pop),
      .out_push (out_push),
      .out_data (out_wdata),
      .out_full (out_full)
   );

   rwtv_queue #(
      .WIDTH ($bits(result_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_wdata),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (out_rdata),
      .empty     (rsp_empty)
   );

   assign rsp_vel_x      = out_rdata.vel_x;
   assign rsp_vel_y      = out_rdata.vel_y;
   assign rsp_vel_z      = out_rdata.vel_z;
   assign rsp_degenerate = out_rdata.degenerate;

endmodule

>>> dv/rotating_wall_tangential_velocity_core_tb.sv
`timescale 1ns / 1ps

module rotating_wall_tangential_velocity_core_tb;
   import rwtv_pkg::*;

   localparam int LatencyWait = 120;
   localparam int IdleLimit   = 20000;

   logic                     clock;
   logic                     reset;
   logic                     req_push;
   logic                     req_full;
   logic signed [CoordW-1:0] req_node_x;
   logic signed [CoordW-1:0] req_node_y;
   logic signed [CoordW-1:0] req_node_z;
   logic [PatchW-1:0]        req_node_patch;
   logic                     rsp_empty;
   logic                     rsp_pop;
   logic signed [CoordW-1:0] rsp_vel_x;
   logic signed [CoordW-1:0] rsp_vel_y;
   logic signed [CoordW-1:0] rsp_vel_z;
   logic                     rsp_degenerate;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [IdxW-1:0]          csr_index;
   logic [CoordW-1:0]        csr_wdata;

   rotating_wall_tangential_velocity_core dut (.*);

   cfg_type    wall_cfg;
   result_type velocity_q[$];
   int         error_count;
   int         nodes_sent;
   int         velocities_checked;
   int         degenerate_seen;
   int         saturated_seen;
   int         idle_cycles;
   int         burst_left;
   bit         req_taken;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want,
               velocities_checked);
   endtask

   function automatic logic [127:0] floor_sqrt(input logic [127:0] q);
      logic [127:0] r;
      logic [127:0] t;
      r = '0;
      for (int b = 50; b >= 0; b--) begin
         t = r | (128'd1 << b);
         if (t * t <= q) r = t;
      end
      return r;
   endfunction

   function automatic logic [31:0] scale_component(input logic signed [127:0] c,
                                                   input logic signed [127:0] rate,
                                                   input logic [127:0] len);
      logic [127:0] mag;
      logic [127:0] rmag;
      logic [127:0] q;
      logic [127:0] rem;
      logic [127:0] lim;
      logic         neg;
      mag  = (c < 0) ? -c : c;
      rmag = (rate < 0) ? -rate : rate;
      q    = (mag * rmag) / len;
      rem  = (mag * rmag) - q * len;
      if (rem >= len - rem) q = q + 1;
      neg = (c < 0) != (rate < 0);
      lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (q > lim) begin
         q = lim;
         saturated_seen++;
      end
      return neg ? 32'(-q) : q[31:0];
   endfunction

   // Returns 1 when the node belongs to the selected patch.
   function automatic bit predict_velocity(input logic signed [31:0] nx,
                                           input logic signed [31:0] ny,
                                           input logic signed [31:0] nz,
                                           input logic [7:0] np,
                                           output result_type vel);
      logic signed [127:0] ax, ay, az, px, py, pz, xx, xy, xz, cx, cy, cz, rate;
      logic [127:0]        plen2;
      logic [127:0]        len;
      vel = '0;
      if (np != wall_cfg.patch) return 0;
      ax = wall_cfg.a_x; ay = wall_cfg.a_y; az = wall_cfg.a_z;
      px = wall_cfg.b_x; py = wall_cfg.b_y; pz = wall_cfg.b_z;
      px = px - ax; py = py - ay; pz = pz - az;
      xx = nx; xy = ny; xz = nz;
      xx = xx - ax; xy = xy - ay; xz = xz - az;
      cx = py * xz - pz * xy;
      cy = pz * xx - px * xz;
      cz = px * xy - py * xx;
      plen2 = px * px + py * py + pz * pz;
      if (plen2 == 0 || (cx == 0 && cy == 0 && cz == 0)) begin
         vel.degenerate = 1'b1;
         return 1;
      end
      len  = floor_sqrt(plen2 << 32);
      rate = wall_cfg.rate;
      vel.vel_x = scale_component(cx, rate, len);
      vel.vel_y = scale_component(cy, rate, len);
      vel.vel_z = scale_component(cz, rate, len);
      return 1;
   endfunction

   // Sends one request; req_push stays high across back-to-back requests of a burst.
   task automatic send_node(input logic [31:0] nx, input logic [31:0] ny,
                            input logic [31:0] nz, input logic [7:0] np);
      result_type vel;
      req_node_x     <= nx;
      req_node_y     <= ny;
      req_node_z     <= nz;
      req_node_patch <= np;
      req_push       <= 1'b1;
      do @(posedge clock); while (req_full);
      nodes_sent++;
      if (predict_velocity(nx, ny, nz, np, vel)) velocity_q = {velocity_q, vel};
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 12);
      end
   endtask

   task automatic drain;
      req_push <= 1'b0;
      @(posedge clock);
      while (velocity_q.size() != 0) @(posedge clock);
      repeat (LatencyWait) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IdxW-1:0] idx, input logic [31:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_AXIS_A_X:     wall_cfg.a_x   = data;
         REG_AXIS_A_Y:     wall_cfg.a_y   = data;
         REG_AXIS_A_Z:     wall_cfg.a_z   = data;
         REG_AXIS_B_X:     wall_cfg.b_x   = data;
         REG_AXIS_B_Y:     wall_cfg.b_y   = data;
         REG_AXIS_B_Z:     wall_cfg.b_z   = data;
         REG_ANGULAR_RATE: wall_cfg.rate  = data;
         REG_TARGET_PATCH: wall_cfg.patch = data[7:0];
         default: ;
      endcase
   endtask

   task automatic set_wall(input logic [31:0] ax, input logic [31:0] ay,
                           input logic [31:0] az, input logic [31:0] bx,
                           input logic [31:0] by, input logic [31:0] bz,
                           input logic [31:0] rate, input logic [7:0] patch);
      drain();
      write_reg(REG_AXIS_A_X, ax);
      write_reg(REG_AXIS_A_Y, ay);
      write_reg(REG_AXIS_A_Z, az);
      write_reg(REG_AXIS_B_X, bx);
      write_reg(REG_AXIS_B_Y, by);
      write_reg(REG_AXIS_B_Z, bz);
      write_reg(REG_ANGULAR_RATE, rate);
      write_reg(REG_TARGET_PATCH, {24'd0, patch});
   endtask

   task automatic test_reset_defaults;
      // Axis along z through the origin, rate zero, patch zero.
      send_node(32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 8'd0);
      send_node(32'h0000_0000, 32'h0000_0000, 32'h1234_0000, 8'd0);
      send_node(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 8'd1);
   endtask

   task automatic test_unit_rotation;
      set_wall(0, 0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 8'd5);
      send_node(32'h0001_0000, 0, 0, 8'd5);
      send_node(0, 32'hFFFF_0000, 32'h0003_0000, 8'd5);
      send_node(32'h0000_8000, 32'h0000_8000, 0, 8'd5);
      send_node(32'h0001_0000, 0, 0, 8'd4);
      send_node(0, 0, 32'h0005_0000, 8'd5);
      send_node(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 8'd5);
   endtask

   task automatic test_extremes;
      set_wall(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd255);
      send_node(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 8'd255);
      send_node(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 8'd255);
      send_node(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'd255);
      send_node(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 8'd255);
      drain();
      write_reg(REG_ANGULAR_RATE, 32'h8000_0000);
      send_node(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 8'd255);
      send_node(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 8'd255);
      send_node(32'h1000_0000, 32'h0000_0000, 32'h0000_0000, 8'd0);
   endtask

   task automatic test_degenerate_axis;
      set_wall(32'h0003_0000, 32'hFFFE_0000, 32'h0001_0000,
               32'h0003_0000, 32'hFFFE_0000, 32'h0001_0000, 32'h0002_0000, 8'd17);
      send_node(32'h0009_0000, 32'h0001_0000, 32'h0000_0000, 8'd17);
      send_node(32'h0003_0000, 32'hFFFE_0000, 32'h0001_0000, 8'd17);
      drain();
      write_reg(REG_AXIS_B_X, 32'h0004_0000);
      send_node(32'h0005_0000, 32'hFFFE_0000, 32'h0001_0000, 8'd17);
      send_node(32'h0003_0000, 32'h0000_0000, 32'h0001_0000, 8'd17);
   endtask

   function automatic logic [31:0] rand_coord(input int mode);
      case (mode)
         0:       return $urandom();
         1:       return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
         default: return 32'($signed($urandom_range(0, 512)) - 256);
      endcase
   endfunction

   task automatic random_wall;
      int mode;
      logic [31:0] rate;
      mode = $urandom_range(0, 2);
      case ($urandom_range(0, 3))
         0:       rate = $urandom();
         1:       rate = 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
         2:       rate = 32'h0000_0000;
         default: rate = {{16{1'b0}}, 16'($urandom())};
      endcase
      set_wall(rand_coord(mode), rand_coord(mode), rand_coord(mode),
               rand_coord(mode), rand_coord(mode), rand_coord(mode), rate,
               8'($urandom()));
   endtask

   task automatic test_random_nodes(input int count);
      logic signed [31:0] k;
      logic [7:0]         np;
      for (int i = 0; i < count; i++) begin
         if (i % 90 == 0) random_wall();
         if (i == count / 2) drain();
         np = ($urandom_range(0, 4) == 0) ? 8'($urandom()) : wall_cfg.patch;
         case ($urandom_range(0, 5))
            0: begin
               // A point on the axis line itself.
               k = $signed($urandom_range(0, 6)) - 3;
               send_node(wall_cfg.a_x + k * (wall_cfg.b_x - wall_cfg.a_x),
                         wall_cfg.a_y + k * (wall_cfg.b_y - wall_cfg.a_y),
                         wall_cfg.a_z + k * (wall_cfg.b_z - wall_cfg.a_z), np);
            end
            1, 2: send_node($urandom(), $urandom(), $urandom(), np);
            default: send_node(wall_cfg.a_x + rand_coord(1), wall_cfg.a_y + rand_coord(2),
                               wall_cfg.a_z + rand_coord(1), np);
         endcase
      end
   endtask

   // Result side: pop pattern changes at random, and each popped result is checked.
   always @(posedge clock) begin
      int pop_mode;
      result_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if ($urandom_range(0, 63) == 0) pop_mode = $urandom_range(0, 3);
         case (pop_mode)
            0:       rsp_pop <= 1'b1;
            1:       rsp_pop <= ($urandom_range(0, 3) != 0);
            2:       rsp_pop <= ($urandom_range(0, 3) == 0);
            default: rsp_pop <= ($urandom_range(0, 31) != 0);
         endcase
         if (rsp_pop && !rsp_empty) begin
            if (velocity_q.size() == 0) begin
               report_mismatch("unexpected result", rsp_vel_x, 32'd0);
            end else begin
               want = velocity_q.pop_front();
               if (rsp_vel_x !== want.vel_x) report_mismatch("vel_x", rsp_vel_x, want.vel_x);
               if (rsp_vel_y !== want.vel_y) report_mismatch("vel_y", rsp_vel_y, want.vel_y);
               if (rsp_vel_z !== want.vel_z) report_mismatch("vel_z", rsp_vel_z, want.vel_z);
               if (rsp_degenerate !== want.degenerate)
                  report_mismatch("degenerate", 32'(rsp_degenerate), 32'(want.degenerate));
               if (want.degenerate) degenerate_seen++;
            end
            velocities_checked++;
         end
      end
   end

   always @(posedge clock) begin
      req_taken = req_push && !req_full;
      if (reset || req_taken || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("Timeout: no request or result moved for %0d cycles", IdleLimit);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      reset          <= 1'b1;
      req_push       <= 1'b0;
      req_node_x     <= '0;
      req_node_y     <= '0;
      req_node_z     <= '0;
      req_node_patch <= '0;
      csr_valid      <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      wall_cfg       = '0;
      wall_cfg.b_z   = AxisBZReset;
      error_count    = 0;
      burst_left     = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_unit_rotation();
      test_extremes();
      test_degenerate_axis();
      test_random_nodes(550);
      drain();
      if (velocity_q.size() != 0) error_count++;
      $display("Sent %0d nodes over many axis settings; checked %0d velocities,", nodes_sent,
               velocities_checked);
      $display("%0d of them degenerate, %0d saturated components predicted.",
               degenerate_seen, saturated_seen);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
